>>> design/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types, constants and helpers for the tile constraint propagation block.
// ----------------------------------------------------------------------------
package tcp_pkg;

	localparam int TYPE_COUNT  = 6;
	localparam int DOM_W       = 6;
	localparam int RND_W       = 16;
	localparam int CFG_W       = 36;
	localparam int CFG_IDX_W   = 3;
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 32;

	localparam logic [DOM_W-1:0] FULL_DOMAIN = 6'h3F;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_ABOVE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_LEFT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_RIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_BELOW = 3'd5;

	localparam logic [6:0]       RST_GRID_WIDTH  = 7'd60;
	localparam logic [5:0]       RST_GRID_HEIGHT = 6'd20;
	localparam logic [CFG_W-1:0] RST_ALLOWED_VERT = 36'd34501353923;
	localparam logic [CFG_W-1:0] RST_ALLOWED_HORZ = 36'd52218094019;

	// neighbor directions
	localparam logic [1:0] DIR_ABOVE = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_BELOW = 2'd3;

	// data handed from one type cell to the next
	typedef struct packed {
		logic [DOM_W-1:0] uni;     // union of allowed masks so far
		logic [2:0]       pick;    // set bits still to skip
		logic             found;
		logic [2:0]       chosen;
	} link_t;

	function automatic logic [2:0] count_types(input logic [DOM_W-1:0] d);
		logic [2:0] n;
		n = '0;
		for (int k = 0; k < DOM_W; k++) begin
			n = n + 3'(d[k]);
		end
		return n;
	endfunction

endpackage

>>> design/tcp_ram.sv
// ----------------------------------------------------------------------------
// tcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcp_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/tcp_type_cell.sv
// ----------------------------------------------------------------------------
// tcp_type_cell
// One tile type: folds its allowed mask into the union and takes part in
// picking the n-th set bit of a domain.
// ----------------------------------------------------------------------------
module tcp_type_cell #(
	parameter int K = 0
) (
	input  logic                      dom_bit,
	input  logic [tcp_pkg::DOM_W-1:0] rule,
	input  tcp_pkg::link_t            link_in,
	output tcp_pkg::link_t            link_out
);

	logic hit;

	assign hit = dom_bit && !link_in.found && (link_in.pick == 3'd0);

	always_comb begin
		link_out       = link_in;
		link_out.uni   = link_in.uni | (dom_bit ? rule : '0);
		link_out.found = link_in.found | hit;
		if (hit) begin
			link_out.chosen = 3'(K);
		end
		if (dom_bit && !link_in.found && (link_in.pick != 3'd0)) begin
			link_out.pick = link_in.pick - 3'd1;
		end
	end

endmodule

>>> design/tile_constraint_propagation_top.sv
// ----------------------------------------------------------------------------
// tile_constraint_propagation_top
// Grid of tile domains: collapse one cell, propagate adjacency rules over a
// stack worklist, then scan for the next cell of least choice other than one.
// ----------------------------------------------------------------------------
// Flow: one item at a time; a modulo pass over the RND_W random bits, then a
//   pick, a visit of each cell popped from the worklist and a row-order scan
//   of the W*H cells in use; a restart first adds a fill pass over all CELLS.
// Throughput: set by the single read port of the domain RAM, shared by the
//   propagation walk and the row-order scan.
// Reset: control registers clear at once, configuration takes its defaults,
//   then a fill pass writes every domain to all types; in_ready stays low during it.
// ----------------------------------------------------------------------------
module tile_constraint_propagation_top #(
	parameter int MAX_WIDTH  = tcp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tcp_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [5:0]                    start_x,
	input  logic [4:0]                    start_y,
	input  logic [15:0]                   random_value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    cell_x,
	output logic [4:0]                    cell_y,
	output logic [2:0]                    chosen_type,
	output logic                          contradiction,
	output logic                          finished,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [tcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcp_pkg::CFG_W-1:0]     cfg_data
);

	// Cells are addressed as {y, x}; each coordinate field is a power of two.
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CW    = XW + YW;
	localparam int CELLS = 1 << CW;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DW    = tcp_pkg::DOM_W;
	localparam int SW    = $clog2(tcp_pkg::RND_W);

	typedef enum logic [3:0] {
		S_FILL, S_IDLE, S_SEL, S_RD, S_MOD, S_PICK, S_POP, S_POPW,
		S_CDOM, S_NISS, S_NEVAL, S_SCAN, S_TAIL, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0]                grid_width_q;
	logic [5:0]                grid_height_q;
	logic [tcp_pkg::CFG_W-1:0] rules_q [4];

	// item state
	logic [XW-1:0]  cx_q;
	logic [YW-1:0]  cy_q;
	logic [15:0]    rnd_q;
	logic [DW-1:0]  dom_q;
	logic [2:0]     cnt_q;
	logic [2:0]     rem_q;
	logic [SW-1:0]  step_q;
	logic [2:0]     chosen_q;
	logic           contra_q;
	logic [CW-1:0]  fill_q;
	logic           restart_q;

	// propagation
	logic [CW:0]    top_q;
	logic [CW-1:0]  c_q;
	logic [DW-1:0]  cdom_q;
	logic [1:0]     d_q;
	logic [CW-1:0]  n_q;

	// scan
	logic [XW-1:0]  sx_q;
	logic [YW-1:0]  sy_q;
	logic           v_s1;
	logic [CW-1:0]  idx_s1;
	logic [2:0]     best_q;
	logic           none_q;
	logic [CW-1:0]  next_cell_q;

	// result register
	logic           out_valid_q;
	logic [5:0]     cell_x_q;
	logic [4:0]     cell_y_q;
	logic [2:0]     chosen_type_q;
	logic           contradiction_q;
	logic           finished_q;

	// RAM ports
	logic           dom_we;
	logic [CW-1:0]  dom_waddr, dom_raddr;
	logic [DW-1:0]  dom_wdata, dom_rdata;
	logic           qd_we;
	logic [CW-1:0]  qd_waddr, qd_raddr;
	logic           qd_wdata, qd_rdata;
	logic           pd_we;
	logic [CW-1:0]  pd_waddr, pd_raddr;
	logic [CW-1:0]  pd_wdata, pd_rdata;

	// grid size in use, saturated to 1..MAX
	logic [WW-1:0]  w_eff;
	logic [HW-1:0]  h_eff;
	logic [XW-1:0]  wlast;
	logic [YW-1:0]  hlast;

	always_comb begin
		if (grid_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(grid_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(grid_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(grid_height_q);
		end
	end

	assign wlast = XW'(w_eff - WW'(1));
	assign hlast = YW'(h_eff - HW'(1));

	// start cell, clamped into the grid in use
	logic [XW-1:0] sel_x;
	logic [YW-1:0] sel_y;
	logic [XW-1:0] nc_x;
	logic [YW-1:0] nc_y;

	assign nc_x = next_cell_q[XW-1:0];
	assign nc_y = next_cell_q[CW-1:XW];

	always_comb begin
		if (!kind) begin
			sel_x = (32'(start_x) > 32'(wlast)) ? wlast : XW'(start_x);
			sel_y = (32'(start_y) > 32'(hlast)) ? hlast : YW'(start_y);
		end else begin
			sel_x = (nc_x > wlast) ? wlast : nc_x;
			sel_y = (nc_y > hlast) ? hlast : nc_y;
		end
	end

	// neighbor of the popped cell in direction d_q
	logic [XW-1:0] cxp, nx;
	logic [YW-1:0] cyp, ny;
	logic          n_ok;

	assign cxp = c_q[XW-1:0];
	assign cyp = c_q[CW-1:XW];

	always_comb begin
		nx   = cxp;
		ny   = cyp;
		n_ok = 1'b0;
		case (d_q)
			tcp_pkg::DIR_ABOVE: begin
				n_ok = (cyp != '0);
				ny   = cyp - YW'(1);
			end
			tcp_pkg::DIR_LEFT: begin
				n_ok = (cxp != '0);
				nx   = cxp - XW'(1);
			end
			tcp_pkg::DIR_RIGHT: begin
				n_ok = (32'(cxp) + 32'd1 < 32'(w_eff));
				nx   = cxp + XW'(1);
			end
			tcp_pkg::DIR_BELOW: begin
				n_ok = (32'(cyp) + 32'd1 < 32'(h_eff));
				ny   = cyp + YW'(1);
			end
			default: begin
				n_ok = 1'b0;
			end
		endcase
	end

	// row of type cells: union of allowed masks, and n-th set bit pick
	tcp_pkg::link_t             chain [tcp_pkg::TYPE_COUNT+1];
	logic [DW-1:0]              chain_dom;
	logic [tcp_pkg::CFG_W-1:0]  chain_rules;

	assign chain_dom   = (state_q == S_PICK) ? dom_q : cdom_q;
	assign chain_rules = rules_q[d_q];
	assign chain[0]    = '{uni: '0, pick: rem_q, found: 1'b0, chosen: 3'd0};

	for (genvar k = 0; k < tcp_pkg::TYPE_COUNT; k++) begin : g_type
		tcp_type_cell #(.K(k)) u_cell (
			.dom_bit  (chain_dom[k]),
			.rule     (chain_rules[DW*k +: DW]),
			.link_in  (chain[k]),
			.link_out (chain[k+1])
		);
	end

	logic [DW-1:0] nv;
	assign nv = dom_rdata & chain[tcp_pkg::TYPE_COUNT].uni;

	// modulo step: one quotient bit per cycle; remainder stays below count
	logic [3:0] r4;
	assign r4 = {rem_q, rnd_q[15]};

	logic [2:0] scan_n;
	assign scan_n = tcp_pkg::count_types(dom_rdata);

	// RAM control
	always_comb begin
		dom_we    = 1'b0;
		dom_waddr = {cy_q, cx_q};
		dom_wdata = tcp_pkg::FULL_DOMAIN;
		dom_raddr = {cy_q, cx_q};
		qd_we     = 1'b0;
		qd_waddr  = n_q;
		qd_wdata  = 1'b1;
		qd_raddr  = {ny, nx};
		pd_we     = 1'b0;
		pd_waddr  = top_q[CW-1:0];
		pd_wdata  = n_q;
		pd_raddr  = CW'(top_q - (CW+1)'(1));
		case (state_q)
			S_FILL: begin
				dom_we    = 1'b1;
				dom_waddr = fill_q;
				qd_we     = 1'b1;
				qd_waddr  = fill_q;
				qd_wdata  = 1'b0;
			end
			S_PICK: begin
				dom_we    = 1'b1;
				dom_wdata = DW'(1) << chain[tcp_pkg::TYPE_COUNT].chosen;
				qd_we     = 1'b1;
				qd_waddr  = {cy_q, cx_q};
				pd_we     = 1'b1;
				pd_waddr  = '0;
				pd_wdata  = {cy_q, cx_q};
			end
			S_POPW: begin
				dom_raddr = pd_rdata;
				qd_we     = 1'b1;
				qd_waddr  = pd_rdata;
				qd_wdata  = 1'b0;
			end
			S_NISS: begin
				dom_raddr = {ny, nx};
			end
			S_NEVAL: begin
				if (nv != dom_rdata) begin
					dom_we    = 1'b1;
					dom_waddr = n_q;
					dom_wdata = nv;
					if (!qd_rdata) begin
						qd_we = 1'b1;
						pd_we = 1'b1;
					end
				end
			end
			S_SCAN: begin
				dom_raddr = {sy_q, sx_q};
			end
			default: begin
				dom_we = 1'b0;
			end
		endcase
	end

	tcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dom (
		.clk(clk), .we(dom_we), .waddr(dom_waddr), .wdata(dom_wdata),
		.raddr(dom_raddr), .rdata(dom_rdata)
	);

	tcp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_queued (
		.clk(clk), .we(qd_we), .waddr(qd_waddr), .wdata(qd_wdata),
		.raddr(qd_raddr), .rdata(qd_rdata)
	);

	tcp_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_pending (
		.clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
		.raddr(pd_raddr), .rdata(pd_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= tcp_pkg::RST_GRID_WIDTH;
			grid_height_q <= tcp_pkg::RST_GRID_HEIGHT;
			rules_q[0]    <= tcp_pkg::RST_ALLOWED_VERT;
			rules_q[1]    <= tcp_pkg::RST_ALLOWED_HORZ;
			rules_q[2]    <= tcp_pkg::RST_ALLOWED_HORZ;
			rules_q[3]    <= tcp_pkg::RST_ALLOWED_VERT;
		end else if (cfg_we) begin
			case (cfg_index)
				tcp_pkg::CFG_GRID_WIDTH:    grid_width_q  <= cfg_data[6:0];
				tcp_pkg::CFG_GRID_HEIGHT:   grid_height_q <= cfg_data[5:0];
				tcp_pkg::CFG_ALLOWED_ABOVE: rules_q[0]    <= cfg_data;
				tcp_pkg::CFG_ALLOWED_LEFT:  rules_q[1]    <= cfg_data;
				tcp_pkg::CFG_ALLOWED_RIGHT: rules_q[2]    <= cfg_data;
				tcp_pkg::CFG_ALLOWED_BELOW: rules_q[3]    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			restart_q   <= 1'b0;
			fill_q      <= '0;
			top_q       <= '0;
			d_q         <= '0;
			v_s1        <= 1'b0;
			none_q      <= 1'b1;
			next_cell_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// scan compare, one cell per cycle behind the read
			if (v_s1 && scan_n != 3'd1 && (none_q || scan_n < best_q)) begin
				best_q      <= scan_n;
				none_q      <= 1'b0;
				next_cell_q <= idx_s1;
			end

			case (state_q)
				S_FILL: begin
					fill_q <= fill_q + CW'(1);
					if (fill_q == CW'(CELLS - 1)) begin
						state_q <= restart_q ? S_SEL : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cx_q      <= sel_x;
						cy_q      <= sel_y;
						rnd_q     <= random_value;
						restart_q <= !kind;
						fill_q    <= '0;
						state_q   <= kind ? S_SEL : S_FILL;
					end
				end
				S_SEL: begin
					state_q <= S_RD;
				end
				S_RD: begin
					dom_q    <= dom_rdata;
					cnt_q    <= tcp_pkg::count_types(dom_rdata);
					rem_q    <= '0;
					step_q   <= '0;
					chosen_q <= '0;
					if (dom_rdata == '0) begin
						contra_q <= 1'b1;
						sx_q     <= '0;
						sy_q     <= '0;
						none_q   <= 1'b1;
						state_q  <= S_SCAN;
					end else begin
						contra_q <= 1'b0;
						state_q  <= S_MOD;
					end
				end
				S_MOD: begin
					rem_q  <= (r4 >= {1'b0, cnt_q}) ? 3'(r4 - {1'b0, cnt_q}) : 3'(r4);
					rnd_q  <= {rnd_q[14:0], 1'b0};
					step_q <= step_q + SW'(1);
					if (step_q == SW'(tcp_pkg::RND_W - 1)) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					chosen_q <= chain[tcp_pkg::TYPE_COUNT].chosen;
					top_q    <= (CW+1)'(1);
					state_q  <= S_POP;
				end
				S_POP: begin
					if (top_q == '0) begin
						sx_q    <= '0;
						sy_q    <= '0;
						none_q  <= 1'b1;
						state_q <= S_SCAN;
					end else begin
						top_q   <= top_q - (CW+1)'(1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					c_q     <= pd_rdata;
					state_q <= S_CDOM;
				end
				S_CDOM: begin
					cdom_q  <= dom_rdata;
					d_q     <= tcp_pkg::DIR_ABOVE;
					state_q <= S_NISS;
				end
				S_NISS: begin
					if (n_ok) begin
						n_q     <= {ny, nx};
						state_q <= S_NEVAL;
					end else if (d_q == tcp_pkg::DIR_BELOW) begin
						state_q <= S_POP;
					end else begin
						d_q <= d_q + 2'd1;
					end
				end
				S_NEVAL: begin
					if (nv != dom_rdata && !qd_rdata) begin
						top_q <= top_q + (CW+1)'(1);
					end
					if (d_q == tcp_pkg::DIR_BELOW) begin
						state_q <= S_POP;
					end else begin
						d_q     <= d_q + 2'd1;
						state_q <= S_NISS;
					end
				end
				S_SCAN: begin
					v_s1   <= 1'b1;
					idx_s1 <= {sy_q, sx_q};
					if (sx_q == wlast) begin
						sx_q <= '0;
						if (sy_q == hlast) begin
							state_q <= S_TAIL;
						end else begin
							sy_q <= sy_q + YW'(1);
						end
					end else begin
						sx_q <= sx_q + XW'(1);
					end
				end
				S_TAIL: begin
					v_s1    <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						cell_x_q        <= 6'(cx_q);
						cell_y_q        <= 5'(cy_q);
						chosen_type_q   <= chosen_q;
						contradiction_q <= contra_q;
						finished_q      <= none_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign cell_x        = cell_x_q;
	assign cell_y        = cell_y_q;
	assign chosen_type   = chosen_type_q;
	assign contradiction = contradiction_q;
	assign finished      = finished_q;

endmodule

>>> test/tile_constraint_propagation_top_test.sv
// ----------------------------------------------------------------------------
// tile_constraint_propagation_top_test
// Self-checking bench for the tile domain grid: drives restart and continue
// items, predicts each result with a behavioral grid model and compares.
// ----------------------------------------------------------------------------
module tile_constraint_propagation_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GW = 64;
	localparam int GH = 32;
	localparam int CELLS = GW * GH;
	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_CONTINUE = 1'b1;

	typedef logic [tcp_pkg::CFG_IDX_W-1:0] reg_idx_t;
	typedef logic [tcp_pkg::CFG_W-1:0] rule_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  sx;
		logic [4:0]  sy;
		logic [15:0] rnd;
	} step_t;

	typedef struct packed {
		logic [5:0] cx;
		logic [4:0] cy;
		logic [2:0] ty;
		logic       contra;
		logic       done;
	} collapse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [5:0] start_x = '0;
	logic [4:0] start_y = '0;
	logic [15:0] random_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] cell_x;
	logic [4:0] cell_y;
	logic [2:0] chosen_type;
	logic contradiction;
	logic finished;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = '0;
	rule_t cfg_data = '0;

	tile_constraint_propagation_top dut (.*);

	always #5 clk = ~clk;

	// ---- predictor state: a private copy of the grid and the rules ----
	logic [6:0] cols_reg;
	logic [5:0] rows_reg;
	rule_t rules [4];  // indexed by DIR_*
	logic [5:0] grid [CELLS];
	int unsigned scan_pick;

	step_t pending_steps[$];
	collapse_t expected_collapses[$];
	int mismatches = 0;
	int transfers_out = 0;
	int restarts = 0, contras = 0, dones = 0;
	int send_idle = 27, recv_idle = 81;
	int items_sent = 0;  // items put on the input by the driver
	int items_in = 0;    // input transfers seen by the monitor

	function automatic int popcount6(logic [5:0] d);
		int n = 0;
		for (int k = 0; k < 6; k++) n += d[k];
		return n;
	endfunction

	function automatic logic [5:0] rule_union(rule_t r, logic [5:0] d);
		logic [5:0] u = '0;
		for (int k = 0; k < 6; k++)
			if (d[k]) u |= r[6*k +: 6];
		return u;
	endfunction

	// Collapse, propagate over a stack worklist, then scan for least choice.
	function automatic collapse_t predict_collapse(step_t s);
		collapse_t r;
		int w, h, cx, cy, c, cnt, pick, best, top, cur;
		int nx, ny, n;
		logic [5:0] d, nv;
		int stack [CELLS];
		bit queued [CELLS];
		int dxs [4] = '{0, -1, 1, 0};
		int dys [4] = '{-1, 0, 0, 1};
		w = cols_reg == 0 ? 1 : (cols_reg > GW ? GW : cols_reg);
		h = rows_reg == 0 ? 1 : (rows_reg > GH ? GH : rows_reg);
		if (s.kind == KIND_RESTART) begin
			foreach (grid[i]) grid[i] = tcp_pkg::FULL_DOMAIN;
			cx = s.sx;
			cy = s.sy;
		end else begin
			cx = scan_pick % GW;
			cy = (scan_pick / GW) % GH;
		end
		if (cx > w - 1) cx = w - 1;
		if (cy > h - 1) cy = h - 1;
		c = cy * GW + cx;
		d = grid[c];
		cnt = popcount6(d);
		r = '0;
		r.cx = 6'(cx);
		r.cy = 5'(cy);
		if (cnt == 0) begin
			r.contra = 1'b1;
		end else begin
			pick = s.rnd % cnt;
			for (int k = 0; k < 6; k++)
				if (d[k]) begin
					if (pick == 0) begin
						r.ty = 3'(k);
						break;
					end
					pick--;
				end
			grid[c] = 6'(1 << r.ty);
			top = 0;
			stack[top++] = c;
			queued[c] = 1;
			while (top > 0) begin
				cur = stack[--top];
				queued[cur] = 0;
				for (int dir = 0; dir < 4; dir++) begin
					nx = cur % GW + dxs[dir];
					ny = cur / GW + dys[dir];
					if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
					n = ny * GW + nx;
					nv = grid[n] & rule_union(rules[dir], grid[cur]);
					if (nv != grid[n]) begin
						grid[n] = nv;
						if (!queued[n]) begin
							queued[n] = 1;
							stack[top++] = n;
						end
					end
				end
			end
		end
		best = 99;
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++) begin
				cnt = popcount6(grid[y*GW + x]);
				if (cnt != 1 && cnt < best) begin
					best = cnt;
					scan_pick = y * GW + x;
				end
			end
		r.done = best == 99;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, want %0d", what, got, want);
		mismatches++;
	endtask

	function automatic void add_step(step_t s);
		pending_steps.insert(pending_steps.size(), s);
	endfunction

	// ---- driver: one transfer per accepted item, new item at falling edge ----
	always @(negedge clk) begin
		if (arst_n) begin
			// the item on the port is done once the monitor has counted it
			if (!in_valid || items_in == items_sent) begin
				if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle) begin
					step_t s;
					s = pending_steps.pop_front();
					items_sent++;
					in_valid <= 1'b1;
					kind <= s.kind;
					start_x <= s.sx;
					start_y <= s.sy;
					random_value <= s.rnd;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	// ---- monitor: predict on input transfer, check on output transfer ----
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			collapse_t e;
			items_in++;
			e = predict_collapse('{kind, start_x, start_y, random_value});
			expected_collapses.insert(expected_collapses.size(), e);
			if (kind == KIND_RESTART) restarts++;
		end
		if (arst_n && out_valid && out_ready) begin
			transfers_out++;
			if (expected_collapses.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				collapse_t e;
				e = expected_collapses.pop_front();
				if (cell_x !== e.cx) report_mismatch("cell_x", cell_x, e.cx);
				if (cell_y !== e.cy) report_mismatch("cell_y", cell_y, e.cy);
				if (chosen_type !== e.ty) report_mismatch("chosen_type", chosen_type, e.ty);
				if (contradiction !== e.contra)
					report_mismatch("contradiction", contradiction, e.contra);
				if (finished !== e.done) report_mismatch("finished", finished, e.done);
				contras += e.contra;
				dones += e.done;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, rule_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tcp_pkg::CFG_GRID_WIDTH: cols_reg = val[6:0];
			tcp_pkg::CFG_GRID_HEIGHT: rows_reg = val[5:0];
			tcp_pkg::CFG_ALLOWED_ABOVE: rules[tcp_pkg::DIR_ABOVE] = val;
			tcp_pkg::CFG_ALLOWED_LEFT: rules[tcp_pkg::DIR_LEFT] = val;
			tcp_pkg::CFG_ALLOWED_RIGHT: rules[tcp_pkg::DIR_RIGHT] = val;
			tcp_pkg::CFG_ALLOWED_BELOW: rules[tcp_pkg::DIR_BELOW] = val;
			default: begin
			end
		endcase
	endtask

	// Let every queued item go through and every result come back.
	task automatic drain();
		wait (pending_steps.size() == 0);
		@(negedge clk);
		while (in_valid || expected_collapses.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic step_t random_step(int restart_pct);
		step_t s;
		s.kind = $urandom_range(99) < restart_pct ? KIND_RESTART : KIND_CONTINUE;
		s.sx = 6'($urandom);
		s.sy = 5'($urandom);
		s.rnd = 16'($urandom);
		return s;
	endfunction

	function automatic rule_t random_rules();
		rule_t r;
		r = rule_t'({$urandom, $urandom});
		// keep most rule sets permissive enough to avoid instant contradictions
		for (int k = 0; k < 6; k++)
			if ($urandom_range(3) != 0) r[6*k + k] = 1'b1;
		return r;
	endfunction

	function automatic void queue_phase(int n, int restart_pct);
		add_step('{KIND_RESTART, 6'($urandom), 5'($urandom), 16'($urandom)});
		for (int i = 1; i < n; i++) add_step(random_step(restart_pct));
	endfunction

	initial begin
		cols_reg = tcp_pkg::RST_GRID_WIDTH;
		rows_reg = tcp_pkg::RST_GRID_HEIGHT;
		rules[tcp_pkg::DIR_ABOVE] = tcp_pkg::RST_ALLOWED_VERT;
		rules[tcp_pkg::DIR_LEFT] = tcp_pkg::RST_ALLOWED_HORZ;
		rules[tcp_pkg::DIR_RIGHT] = tcp_pkg::RST_ALLOWED_HORZ;
		rules[tcp_pkg::DIR_BELOW] = tcp_pkg::RST_ALLOWED_VERT;
		foreach (grid[i]) grid[i] = tcp_pkg::FULL_DOMAIN;
		scan_pick = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: continue from reset, corner and saturated starts, extreme randoms.
		add_step('{KIND_CONTINUE, 6'd0, 5'd0, 16'hFFFF});
		add_step('{KIND_RESTART, 6'd63, 5'd31, 16'h0000});
		add_step('{KIND_RESTART, 6'd0, 5'd0, 16'hFFFF});
		add_step('{KIND_RESTART, 6'h2A, 5'h15, 16'hAAAA});
		add_step('{KIND_RESTART, 6'h15, 5'h0A, 16'h5555});
		for (int i = 0; i < 4; i++)
			add_step('{KIND_CONTINUE, 6'h3F, 5'h1F, 16'(i * 16'h4001)});
		drain();

		// Tiny grid that finishes, then a continue after finish re-collapses.
		write_reg(tcp_pkg::CFG_GRID_WIDTH, 36'd2);
		write_reg(tcp_pkg::CFG_GRID_HEIGHT, 36'd1);
		add_step('{KIND_RESTART, 6'd5, 5'd3, 16'd7});
		for (int i = 0; i < 3; i++) add_step('{KIND_CONTINUE, 6'd0, 5'd0, 16'd3});
		drain();

		// Zero sizes saturate to 1x1; contradiction from empty rule sets.
		write_reg(tcp_pkg::CFG_GRID_WIDTH, 36'd0);
		write_reg(tcp_pkg::CFG_GRID_HEIGHT, 36'd0);
		add_step('{KIND_RESTART, 6'd9, 5'd9, 16'd1});
		add_step('{KIND_CONTINUE, 6'd0, 5'd0, 16'd1});
		drain();
		write_reg(tcp_pkg::CFG_GRID_WIDTH, 36'd3);
		write_reg(tcp_pkg::CFG_GRID_HEIGHT, 36'd2);
		for (int d = 0; d < 4; d++)
			write_reg(reg_idx_t'(tcp_pkg::CFG_ALLOWED_ABOVE + d), '0);
		add_step('{KIND_RESTART, 6'd1, 5'd0, 16'd2});
		for (int i = 0; i < 3; i++) add_step('{KIND_CONTINUE, 6'd0, 5'd0, 16'd4});
		drain();
		// All-ones rules, oversized width and height saturate to the max grid.
		for (int d = 0; d < 4; d++)
			write_reg(reg_idx_t'(tcp_pkg::CFG_ALLOWED_ABOVE + d), '1);
		write_reg(tcp_pkg::CFG_GRID_WIDTH, 36'h7F);
		write_reg(tcp_pkg::CFG_GRID_HEIGHT, 36'h3F);
		add_step('{KIND_RESTART, 6'd63, 5'd31, 16'hFFFF});
		add_step('{KIND_CONTINUE, 6'd0, 5'd0, 16'h8000});
		drain();

		// Random phases: small grids mostly, idling pattern swapped, then none.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle = 81;
				recv_idle = 27;
			end
			if (ph == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_reg(tcp_pkg::CFG_GRID_WIDTH,
				ph == 5 ? 36'd64 : 36'($urandom_range(1, 12)));
			write_reg(tcp_pkg::CFG_GRID_HEIGHT,
				ph == 5 ? 36'd32 : 36'($urandom_range(1, 8)));
			for (int d = 0; d < 4; d++)
				write_reg(reg_idx_t'(tcp_pkg::CFG_ALLOWED_ABOVE + d), random_rules());
			queue_phase(ph == 5 ? 10 : 22, 10);
			drain();
		end

		$display("Covered %0d result transfers: %0d restarts, %0d contradictions, %0d finished.",
			transfers_out, restarts, contras, dones);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#200ms;
		$display("Timeout");
		$display("Mismatches found");
		$finish;
	end
endmodule

>>> tile_constraint_propagation_top.f
design/tcp_pkg.sv
design/tcp_ram.sv
design/tcp_type_cell.sv
design/tile_constraint_propagation_top.sv
test/tile_constraint_propagation_top_test.sv
